/* sv/bqf_pkg.sv */
// shared types, register codes and sizes for the multichannel biquad filter
package bqf_pkg;

    localparam int BQF_MAX_CHANNELS = 8;
    localparam int BQF_DATA_W       = 32;
    localparam int BQF_CH_W         = 3;
    localparam int BQF_FRAC_W       = 5;
    localparam int BQF_ACC_W        = 64;
    localparam int BQF_CFG_IDX_W    = 3;

    // configuration register indexes
    localparam logic [BQF_CFG_IDX_W-1:0] CFG_B0   = 3'd0;
    localparam logic [BQF_CFG_IDX_W-1:0] CFG_B1   = 3'd1;
    localparam logic [BQF_CFG_IDX_W-1:0] CFG_B2   = 3'd2;
    localparam logic [BQF_CFG_IDX_W-1:0] CFG_A1   = 3'd3;
    localparam logic [BQF_CFG_IDX_W-1:0] CFG_A2   = 3'd4;
    localparam logic [BQF_CFG_IDX_W-1:0] CFG_FRAC = 3'd5;

    localparam logic [BQF_FRAC_W-1:0] FRAC_RESET = 5'd30;

    typedef struct packed {
        logic signed [BQF_DATA_W-1:0] sample_in;
        logic        [BQF_CH_W-1:0]   channel;
    } bqf_in_t;

    typedef struct packed {
        logic signed [BQF_DATA_W-1:0] sample_out;
        logic        [BQF_CH_W-1:0]   channel_out;
        logic                         overflow;
    } bqf_out_t;

    typedef struct packed {
        logic signed [BQF_DATA_W-1:0] b0;
        logic signed [BQF_DATA_W-1:0] b1;
        logic signed [BQF_DATA_W-1:0] b2;
        logic signed [BQF_DATA_W-1:0] a1;
        logic signed [BQF_DATA_W-1:0] a2;
        logic        [BQF_FRAC_W-1:0] frac_bits;
    } bqf_coef_t;

    // per-channel history: two past inputs, two past outputs
    typedef struct packed {
        logic signed [BQF_DATA_W-1:0] x1;
        logic signed [BQF_DATA_W-1:0] x2;
        logic signed [BQF_DATA_W-1:0] y1;
        logic signed [BQF_DATA_W-1:0] y2;
    } bqf_hist_t;

endpackage

/* sv/multichannel_biquad_fixed_point.sv */
// top level of the multichannel direct form I fixed-point biquad
//
//  channel   signals                                   transfer when
//  -------   ---------------------------------------   -------------------------
//  input     in_valid, in_stall, in_data (bqf_in_t)    in_valid && !in_stall
//  output    out_valid, out_stall, out_data (bqf_out_t) out_valid && !out_stall
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// one sample per cycle sustained while out_stall is low; a result is computed from
// the input and history read registers and registered in the output register, from
// which it can transfer out
// the per-channel recurrence closes within the compute stage: history bypass, five
// parallel 32x32 multipliers, 64-bit sum and barrel shift
// reset clears coefficients, sets frac_bits to 30 and marks all channel
// history as zero through per-channel valid bits, no clearing sweep
// in_stall rises only while both the compute stage and the output register
// are full and out_stall is high
module multichannel_biquad_fixed_point #(
    parameter int MAX_CHANNELS = bqf_pkg::BQF_MAX_CHANNELS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  bqf_pkg::bqf_in_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output bqf_pkg::bqf_out_t                    out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bqf_pkg::BQF_CFG_IDX_W-1:0]    cfg_index,
    input  logic [bqf_pkg::BQF_DATA_W-1:0]       cfg_data
);
    import bqf_pkg::*;

    // compute stage
    logic      s1_valid_reg;
    logic      s1_valid_next;
    bqf_in_t   s1_data_reg;

    // output register
    logic      out_valid_reg;
    logic      out_valid_next;
    bqf_out_t  out_data_reg;
    bqf_out_t  out_data_next;

    logic      out_free;
    logic      s1_move;
    logic      in_xfer;
    logic      in_range;

    bqf_coef_t coef;
    bqf_hist_t hist;
    bqf_hist_t hist_wr;
    logic signed [BQF_DATA_W-1:0] y;
    logic      ovf;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    bqf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // handshake: output register frees up when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    // channels beyond the configured count pass through with zero result
    assign in_range = 32'(s1_data_reg.channel) < 32'(MAX_CHANNELS);

    // history write-back: shift in the new input and new output
    assign hist_wr.x1 = s1_data_reg.sample_in;
    assign hist_wr.x2 = hist.x1;
    assign hist_wr.y1 = y;
    assign hist_wr.y2 = hist.y1;

    bqf_hist_mem #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_xfer),
        .rd_ch   (in_data.channel),
        .wr_en   (s1_move && in_range),
        .wr_ch   (s1_data_reg.channel),
        .wr_data (hist_wr),
        .rd_data (hist)
    );

    bqf_mac u_mac (
        .x    (s1_data_reg.sample_in),
        .hist (hist),
        .coef (coef),
        .y    (y),
        .ovf  (ovf)
    );

    always_comb
    begin
        out_data_next.channel_out = s1_data_reg.channel;
        out_data_next.sample_out  = in_range ? y : '0;
        out_data_next.overflow    = in_range && ovf;
    end

    assign s1_valid_next  = in_xfer || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sv/bqf_cfg_regs.sv */
// coefficient and shift registers behind the configuration write port
module bqf_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [bqf_pkg::BQF_CFG_IDX_W-1:0]    cfg_index,
    input  logic [bqf_pkg::BQF_DATA_W-1:0]       cfg_data,
    output bqf_pkg::bqf_coef_t                   coef
);
    import bqf_pkg::*;

    // coefficients cleared, shift at its reset value
    localparam bqf_coef_t COEF_RESET = '{
        b0:        '0,
        b1:        '0,
        b2:        '0,
        a1:        '0,
        a2:        '0,
        frac_bits: FRAC_RESET
    };

    bqf_coef_t coef_reg;
    bqf_coef_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_B0:   coef_next.b0        = cfg_data;
                CFG_B1:   coef_next.b1        = cfg_data;
                CFG_B2:   coef_next.b2        = cfg_data;
                CFG_A1:   coef_next.a1        = cfg_data;
                CFG_A2:   coef_next.a2        = cfg_data;
                CFG_FRAC: coef_next.frac_bits = cfg_data[BQF_FRAC_W-1:0];
                default:  coef_next           = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

/* sv/bqf_hist_mem.sv */
// per-channel history memory with valid bits and same-cycle write bypass
module bqf_hist_mem #(
    parameter int MAX_CHANNELS = bqf_pkg::BQF_MAX_CHANNELS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [bqf_pkg::BQF_CH_W-1:0]   rd_ch,
    input  logic                           wr_en,
    input  logic [bqf_pkg::BQF_CH_W-1:0]   wr_ch,
    input  bqf_pkg::bqf_hist_t             wr_data,
    output bqf_pkg::bqf_hist_t             rd_data
);
    import bqf_pkg::*;

    localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    bqf_hist_t               mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] valid_reg;
    bqf_hist_t               mem_rd_reg;
    logic                    rd_valid_reg;
    logic                    byp_reg;
    bqf_hist_t               byp_data_reg;

    logic [CH_AW-1:0] rd_idx;
    logic [CH_AW-1:0] wr_idx;
    logic             byp_hit;

    assign rd_idx  = CH_AW'(rd_ch);
    assign wr_idx  = CH_AW'(wr_ch);
    // write landing on the edge of the read: take the new value
    assign byp_hit = wr_en && (wr_ch == rd_ch);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
                byp_reg      <= byp_hit;
            end
        end
    end

    // never-written channel reads as cleared history
    always_comb
    begin
        if (byp_reg)
        begin
            rd_data = byp_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_data = mem_rd_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

/* sv/bqf_mac.sv */
// five-term multiply-accumulate, arithmetic shift and range check
module bqf_mac (
    input  logic signed [bqf_pkg::BQF_DATA_W-1:0] x,
    input  bqf_pkg::bqf_hist_t                    hist,
    input  bqf_pkg::bqf_coef_t                    coef,
    output logic signed [bqf_pkg::BQF_DATA_W-1:0] y,
    output logic                                  ovf
);
    import bqf_pkg::*;

    logic signed [BQF_DATA_W-1:0] b0, b1, b2, a1, a2;
    logic signed [BQF_DATA_W-1:0] x1, x2, y1, y2;
    logic signed [BQF_ACC_W-1:0]  p0, p1, p2, p3, p4;
    logic signed [BQF_ACC_W-1:0]  acc;
    logic signed [BQF_ACC_W-1:0]  sh;
    logic [BQF_ACC_W-BQF_DATA_W:0] top_bits;

    assign b0 = coef.b0;
    assign b1 = coef.b1;
    assign b2 = coef.b2;
    assign a1 = coef.a1;
    assign a2 = coef.a2;
    assign x1 = hist.x1;
    assign x2 = hist.x2;
    assign y1 = hist.y1;
    assign y2 = hist.y2;

    // 32x32 signed products, exact in 64 bits
    assign p0 = b0 * x;
    assign p1 = b1 * x1;
    assign p2 = b2 * x2;
    assign p3 = a1 * y1;
    assign p4 = a2 * y2;

    // wraps modulo 2^64
    assign acc = p0 + p1 + p2 - p3 - p4;
    assign sh  = acc >>> coef.frac_bits;

    assign y        = sh[BQF_DATA_W-1:0];
    assign top_bits = sh[BQF_ACC_W-1:BQF_DATA_W-1];
    assign ovf      = !((&top_bits) || !(|top_bits));

endmodule

/* sv/bqf_checker.sv */
// port-level assertions for the biquad top level and their bind
module bqf_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input bqf_pkg::bqf_out_t                    out_data,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready
);
    import bqf_pkg::*;

    // result held steady while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // input backs up only when a full output side is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // an accepted sample reaches the output if not blocked once it sits in the compute stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("accepted sample did not reach the output");

    // no result right out of reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result present after reset");

    // configuration writes never blocked
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write blocked");

endmodule

bind multichannel_biquad_fixed_point bqf_checker u_bqf_checker (.*);

/* tb/biquad_output_checker.sv */
// result predictor and comparator for the multichannel biquad filter
`timescale 1ns / 1ps

module biquad_output_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  bqf_pkg::bqf_in_t                     in_data,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  bqf_pkg::bqf_out_t                    out_data,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [bqf_pkg::BQF_CFG_IDX_W-1:0]    cfg_index,
    input  logic [bqf_pkg::BQF_DATA_W-1:0]       cfg_data,
    output int                                   mismatch_count,
    output int                                   outstanding
);
    import bqf_pkg::*;

    bqf_coef_t coefs;
    bqf_hist_t history [BQF_MAX_CHANNELS];
    bqf_out_t  expected_results [$];
    int        errors;

    // one direct form I step: exact products, sum wraps at 64 bits, then shift
    function automatic bqf_out_t run_biquad(input bqf_in_t item);
        bqf_out_t          res;
        bqf_hist_t         h;
        longint            acc;
        longint            shifted;
        logic signed [31:0] y;
        res.channel_out = item.channel;
        res.sample_out  = '0;
        res.overflow    = 1'b0;
        if (int'(item.channel) >= BQF_MAX_CHANNELS)
            return res;
        h = history[item.channel];
        acc = longint'(coefs.b0) * longint'(item.sample_in)
            + longint'(coefs.b1) * longint'(h.x1)
            + longint'(coefs.b2) * longint'(h.x2)
            - longint'(coefs.a1) * longint'(h.y1)
            - longint'(coefs.a2) * longint'(h.y2);
        shifted = acc >>> coefs.frac_bits;
        y = shifted[31:0];
        res.sample_out = y;
        res.overflow   = (longint'(y) != shifted);
        h.x2 = h.x1;
        h.x1 = item.sample_in;
        h.y2 = h.y1;
        h.y1 = y;
        history[item.channel] = h;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bqf_out_t want;
        bit       bad;
        if (!rst_n)
        begin
            coefs = '0;
            coefs.frac_bits = FRAC_RESET;
            for (int c = 0; c < BQF_MAX_CHANNELS; c++)
                history[c] = '0;
            expected_results.delete();
            errors = 0;
            mismatch_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            // results pass the compute and output registers, so pop first
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result expected none actual %h",
                             $time, out_data);
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad = 1'b0;
                    if (out_data.sample_out !== want.sample_out)
                    begin
                        bad = 1'b1;
                        $display("%0t: sample_out expected %h actual %h",
                                 $time, want.sample_out, out_data.sample_out);
                    end
                    if (out_data.channel_out !== want.channel_out)
                    begin
                        bad = 1'b1;
                        $display("%0t: channel_out expected %0d actual %0d",
                                 $time, want.channel_out, out_data.channel_out);
                    end
                    if (out_data.overflow !== want.overflow)
                    begin
                        bad = 1'b1;
                        $display("%0t: overflow expected %b actual %b",
                                 $time, want.overflow, out_data.overflow);
                    end
                    if (bad)
                        errors++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_B0:   coefs.b0 = cfg_data;
                    CFG_B1:   coefs.b1 = cfg_data;
                    CFG_B2:   coefs.b2 = cfg_data;
                    CFG_A1:   coefs.a1 = cfg_data;
                    CFG_A2:   coefs.a2 = cfg_data;
                    CFG_FRAC: coefs.frac_bits = cfg_data[BQF_FRAC_W-1:0];
                    default:  ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_results.push_back(run_biquad(in_data));
            mismatch_count <= errors;
            outstanding <= expected_results.size();
        end
    end

endmodule

/* tb/multichannel_biquad_fixed_point_test.sv */
// stimulus, handshake idling and verdict for the multichannel biquad filter
`timescale 1ns / 1ps

module multichannel_biquad_fixed_point_test;
    import bqf_pkg::*;

    // indexes past the last register, written once to show they are ignored
    localparam logic [BQF_CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [BQF_CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 204;
    // result register plus history stage, with margin
    localparam int SETTLE_CYCLES = 4;

    localparam logic [31:0] S_MAX   = 32'h7fff_ffff;
    localparam logic [31:0] S_MIN   = 32'h8000_0000;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // how coefficients are drawn for one random phase
    typedef enum int {MIX_WIDE, MIX_GENTLE, MIX_EDGE} coef_mix_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    bqf_in_t                  in_data;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    bqf_out_t                 out_data;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [BQF_CFG_IDX_W-1:0] cfg_index;
    logic [BQF_DATA_W-1:0]    cfg_data;
    int                       mismatch_count;
    int                       outstanding;

    // quiet phases run with no gaps on either side
    bit quiet = 1'b1;
    int stall_hold = 0;
    int rr_channel = 0;

    multichannel_biquad_fixed_point #(
        .MAX_CHANNELS (BQF_MAX_CHANNELS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    biquad_output_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #5 clk = ~clk;

    // hard stop: worst case is roughly 1650 transfers
    initial
    begin
        #10_000_000;
        $display("multichannel_biquad_fixed_point: mismatch");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 4))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic logic [31:0] pick_coef(input coef_mix_t mix);
        case (mix)
            MIX_WIDE:   return $urandom();
            // within +-1/8 in Q30, so feedback rarely runs away
            MIX_GENTLE: return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
            default:    return extreme_word();
        endcase
    endfunction

    function automatic logic [31:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom();
        else if (r < 75)
            return $urandom_range(0, 4000) - 2000;
        else if (r < 90)
            return extreme_word();
        else
            return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endfunction

    // half the time interleave channels in order, else jump at random
    function automatic logic [BQF_CH_W-1:0] pick_channel();
        if ($urandom_range(0, 1))
        begin
            rr_channel = (rr_channel + 1) % BQF_MAX_CHANNELS;
            return rr_channel[BQF_CH_W-1:0];
        end
        return BQF_CH_W'($urandom_range(0, BQF_MAX_CHANNELS - 1));
    endfunction

    // output back-pressure: random levels, each held for a random length
    always @(posedge clk)
    begin
        if (quiet)
        begin
            out_stall <= 1'b0;
            stall_hold = 0;
        end
        else if (stall_hold > 0)
            stall_hold = stall_hold - 1;
        else
        begin
            out_stall <= ($urandom_range(0, 9) < 4);
            stall_hold = pick_gap();
        end
    end

    // one sample transfer; valid stays high into the next call unless a gap is taken
    task automatic send_sample(input logic [31:0] value, input logic [BQF_CH_W-1:0] ch);
        bqf_in_t item;
        int      gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.sample_in = value;
        item.channel   = ch;
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // one register transfer; caller drops cfg_valid after the last one
    task automatic write_reg(input logic [BQF_CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // stop sending and let every expected result come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] b0, input logic [31:0] b1,
                             input logic [31:0] b2, input logic [31:0] a1,
                             input logic [31:0] a2, input logic [BQF_FRAC_W-1:0] frac,
                             input bit with_spare);
        wait_idle();
        write_reg(CFG_B0, b0);
        write_reg(CFG_B1, b1);
        write_reg(CFG_B2, b2);
        write_reg(CFG_A1, a1);
        write_reg(CFG_A2, a2);
        write_reg(CFG_FRAC, {{(32 - BQF_FRAC_W){1'b0}}, frac});
        if (with_spare)
        begin
            write_reg(CFG_SPARE_6, $urandom());
            write_reg(CFG_SPARE_7, $urandom());
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        coef_mix_t              mix;
        logic [BQF_FRAC_W-1:0]  frac;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients are all zero: extremes must come out as zero
        send_sample(S_MAX, 3'd0);
        send_sample(S_MIN, 3'd7);

        // unity gain in Q30: full-scale values pass straight through
        configure(ONE_Q30, '0, '0, '0, '0, FRAC_RESET, 1'b0);
        send_sample(S_MAX, 3'd1);
        send_sample(S_MIN, 3'd2);
        send_sample(32'h0000_0000, 3'd3);
        send_sample(32'hffff_ffff, 3'd4);
        send_sample(32'h0000_0001, 3'd5);

        // most negative everywhere with no shift: accumulator wrap and overflow
        configure(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 5'd0, 1'b0);
        send_sample(S_MIN, 3'd6);
        send_sample(S_MIN, 3'd6);
        send_sample(S_MIN, 3'd6);
        send_sample(S_MAX, 3'd6);

        // most positive everywhere with the widest shift
        configure(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 5'd31, 1'b0);
        send_sample(S_MAX, 3'd0);
        send_sample(S_MAX, 3'd0);
        send_sample(S_MIN, 3'd0);
        send_sample(S_MAX, 3'd0);

        // stable low-pass with feedback, poles at 0.75 and 0.5, all channels
        // interleaved; the unused register indexes are written on the way
        quiet = 1'b0;
        configure(32'h1000_0000, 32'h2000_0000, 32'h1000_0000, 32'hb000_0000,
                  32'h1800_0000, FRAC_RESET, 1'b1);
        for (int k = 0; k < BQF_MAX_CHANNELS; k++)
            send_sample(k[0] ? S_MIN : S_MAX, k[BQF_CH_W-1:0]);

        // random phases, each with its own coefficient set
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            mix = coef_mix_t'(ph % 3);
            if (mix == MIX_EDGE)
                frac = (ph % 2) ? 5'd31 : 5'd0;
            else if (mix == MIX_GENTLE)
                frac = BQF_FRAC_W'($urandom_range(28, 30));
            else
                frac = BQF_FRAC_W'($urandom_range(0, 31));
            configure(pick_coef(mix), pick_coef(mix), pick_coef(mix), pick_coef(mix),
                      pick_coef(mix), frac, 1'b0);
            quiet = (ph % 4 == 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_sample(pick_sample(), pick_channel());
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("multichannel_biquad_fixed_point: match");
        else
            $display("multichannel_biquad_fixed_point: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
sv/bqf_pkg.sv
sv/bqf_cfg_regs.sv
sv/bqf_hist_mem.sv
sv/bqf_mac.sv
sv/multichannel_biquad_fixed_point.sv
sv/bqf_checker.sv
tb/biquad_output_checker.sv
tb/multichannel_biquad_fixed_point_test.sv
